// ----- rtl/rfrx_pkg.sv -----
// ---------------------------------------------------------------------------
// rfrx_pkg
// Shared types and constants for the serial frame receiver.
// ---------------------------------------------------------------------------
package rfrx_pkg;

  localparam int PAYLOAD_BYTES = 17;
  localparam int BODY_END      = 5 + PAYLOAD_BYTES;
  localparam int FRAME_LEN     = BODY_END + 2;
  localparam int CHECK_POS     = FRAME_LEN - 2;
  localparam int IDX_W         = $clog2(FRAME_LEN);
  localparam int FILL_W        = $clog2(FRAME_LEN + 1);
  localparam int POS_W         = 5;
  localparam int ADDR_W        = 4;

  typedef logic [7:0]        byte_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [FILL_W-1:0] fill_t;
  typedef logic [POS_W-1:0]  pos_t;

  // register index codes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_START  = 2'd0,
    REG_HEADER = 2'd1,
    REG_END    = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  localparam byte_t START_RST  = 8'h02;
  localparam byte_t HEADER_RST = 8'h00;
  localparam byte_t END_RST    = 8'h03;

  typedef enum logic [3:0] {
    ST_START,
    ST_HEADER,
    ST_DEST,
    ST_SRC,
    ST_CMD,
    ST_DATA,
    ST_CHECK,
    ST_END,
    ST_REPLAY
  } state_t;

  typedef struct packed {
    byte_t start_byte;
    byte_t header_byte;
    byte_t end_byte;
  } cfg_t;

  typedef struct packed {
    logic clr;        // fill count, running XOR and read pointer to zero
    logic wr;         // store byte at fill count, advance it
    logic xor_load;   // running XOR := byte
    logic xor_acc;    // running XOR ^= byte
    logic chk_cap;    // capture checksum compare
    logic rd_inc;     // advance replay pointer
  } dp_cmd_t;

  typedef struct packed {
    logic match_start;
    logic match_header;
    logic match_end;
    logic body_last;
    logic rd_last;
  } dp_stat_t;

  function automatic pos_t to_pos(idx_t idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[POS_W-1:0];
  endfunction

endpackage

// ----- rtl/rfrx_datapath.sv -----
// ---------------------------------------------------------------------------
// rfrx_datapath
// Frame store, fill count, running XOR, check flag and replay pointer.
// ---------------------------------------------------------------------------
module rfrx_datapath (
  input  logic              clk,
  input  logic              rst,
  input  rfrx_pkg::cfg_t    cfg,
  input  rfrx_pkg::byte_t   rx_byte,
  input  rfrx_pkg::dp_cmd_t cmd,
  output rfrx_pkg::dp_stat_t stat,
  output rfrx_pkg::byte_t   frame_byte,
  output rfrx_pkg::pos_t    byte_position,
  output logic              check_ok,
  output logic              last
);
  import rfrx_pkg::*;

  byte_t frame_store [FRAME_LEN];
  fill_t fill_count;
  byte_t running_xor;
  idx_t  rd_pos;
  logic  chk_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count  <= '0;
      running_xor <= '0;
      rd_pos      <= '0;
      chk_ok      <= 1'b0;
    end else begin
      if (cmd.clr) begin
        fill_count  <= '0;
        running_xor <= '0;
        rd_pos      <= '0;
      end else begin
        if (cmd.wr) begin
          fill_count <= fill_count + 1'b1;
        end
        if (cmd.xor_load) begin
          running_xor <= rx_byte;
        end else if (cmd.xor_acc) begin
          running_xor <= running_xor ^ rx_byte;
        end
        if (cmd.rd_inc) begin
          rd_pos <= rd_pos + 1'b1;
        end
      end
      // check byte lands at CHECK_POS, so compare on the way in
      if (cmd.chk_cap) begin
        chk_ok <= (running_xor == rx_byte);
      end
    end
  end

  // frame store, no reset
  always_ff @(posedge clk) begin
    if (cmd.wr && !cmd.clr) begin
      frame_store[fill_count[IDX_W-1:0]] <= rx_byte;
    end
  end

  assign stat.match_start  = (rx_byte == cfg.start_byte);
  assign stat.match_header = (rx_byte == cfg.header_byte);
  assign stat.match_end    = (rx_byte == cfg.end_byte);
  assign stat.body_last    = (fill_count == FILL_W'(BODY_END - 1));
  assign stat.rd_last      = (rd_pos == IDX_W'(FRAME_LEN - 1));

  assign frame_byte    = frame_store[rd_pos];
  assign byte_position = to_pos(rd_pos);
  assign check_ok      = chk_ok;
  assign last          = stat.rd_last;

endmodule

// ----- rtl/rfrx_ctrl.sv -----
// ---------------------------------------------------------------------------
// rfrx_ctrl
// Frame sequencer: hunts, walks the frame fields, then drives replay.
// ---------------------------------------------------------------------------
module rfrx_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                command,
  input  logic                out_stall,
  input  rfrx_pkg::dp_stat_t  stat,
  output rfrx_pkg::dp_cmd_t   cmd,
  output logic                in_stall,
  output logic                out_valid
);
  import rfrx_pkg::*;

  state_t state, state_next;
  logic   take;
  logic   sent;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_START;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = (state == ST_REPLAY);
  assign out_valid = (state == ST_REPLAY);
  assign take      = in_valid && !in_stall;
  assign sent      = out_valid && !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    if (take && command) begin
      // restart: drop any partial frame
      cmd.clr    = 1'b1;
      state_next = ST_START;
    end else begin
      unique case (state)
        ST_START: begin
          if (take && stat.match_start) begin
            cmd.wr     = 1'b1;
            state_next = ST_HEADER;
          end
        end
        ST_HEADER: begin
          if (take) begin
            if (stat.match_header) begin
              cmd.wr       = 1'b1;
              cmd.xor_load = 1'b1;
              state_next   = ST_DEST;
            end else begin
              cmd.clr    = 1'b1;
              state_next = ST_START;
            end
          end
        end
        ST_DEST, ST_SRC, ST_CMD: begin
          if (take) begin
            cmd.wr      = 1'b1;
            cmd.xor_acc = 1'b1;
            unique case (state)
              ST_DEST: state_next = ST_SRC;
              ST_SRC:  state_next = ST_CMD;
              default: state_next = ST_DATA;
            endcase
          end
        end
        ST_DATA: begin
          if (take) begin
            cmd.wr      = 1'b1;
            cmd.xor_acc = 1'b1;
            if (stat.body_last) begin
              state_next = ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (take) begin
            cmd.wr      = 1'b1;
            cmd.chk_cap = 1'b1;
            state_next  = ST_END;
          end
        end
        ST_END: begin
          if (take) begin
            if (stat.match_end) begin
              cmd.wr     = 1'b1;
              state_next = ST_REPLAY;
            end else begin
              cmd.clr    = 1'b1;
              state_next = ST_START;
            end
          end
        end
        ST_REPLAY: begin
          if (sent) begin
            if (stat.rd_last) begin
              cmd.clr    = 1'b1;
              state_next = ST_START;
            end else begin
              cmd.rd_inc = 1'b1;
            end
          end
        end
        default: begin
          state_next = ST_START;
        end
      endcase
    end
  end

endmodule

// ----- rtl/rs485_frame_receiver_xor_check.sv -----
// ---------------------------------------------------------------------------
// rs485_frame_receiver_xor_check
// Serial frame receiver: start/header hunt, field capture, XOR check and
// replay of the stored frame as a run of words.
// ---------------------------------------------------------------------------
//
//  channel | handshake             | words
//  --------+-----------------------+--------------------------------------------
//  in      | in_valid / in_stall   | command, rx_byte
//  out     | out_valid / out_stall | frame_byte, byte_position, check_ok, last
//  cfg     | APB psel/penable      | start_byte @0x0, header_byte @0x4, end_byte @0x8
//
//  Received bytes are taken one per cycle while in_stall is low. An accepted end
//  byte starts a replay of FRAME_LEN (24) words from the register frame store,
//  one per cycle while out_stall stays low.
//  in_stall is high for the whole replay; out_stall holds the current word.
//  rst is synchronous: sequencer hunts, counters clear, registers take their
//  reset values. The frame store itself is not reset.
// ---------------------------------------------------------------------------
module rs485_frame_receiver_xor_check (
  input  logic                       clk,
  input  logic                       rst,
  // received byte channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       command,
  input  rfrx_pkg::byte_t            rx_byte,
  // replayed frame channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output rfrx_pkg::byte_t            frame_byte,
  output rfrx_pkg::pos_t             byte_position,
  output logic                       check_ok,
  output logic                       last,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rfrx_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import rfrx_pkg::*;

  cfg_t     cfg;
  reg_idx_t reg_sel;
  logic     cfg_wr;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // word-aligned register map, low address bits ignored
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte  <= START_RST;
      cfg.header_byte <= HEADER_RST;
      cfg.end_byte    <= END_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_START:  cfg.start_byte  <= pwdata[7:0];
        REG_HEADER: cfg.header_byte <= pwdata[7:0];
        REG_END:    cfg.end_byte    <= pwdata[7:0];
        default:    ;   // unmapped: write ignored
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_START:  prdata = {24'd0, cfg.start_byte};
      REG_HEADER: prdata = {24'd0, cfg.header_byte};
      REG_END:    prdata = {24'd0, cfg.end_byte};
      default:    prdata = '0;
    endcase
  end

  // sequencer: owns handshakes and frame phase
  rfrx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .command   (command),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  // store, XOR and replay pointer; output words read straight from the store,
  // which is frozen during replay so a stalled word holds
  rfrx_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .rx_byte       (rx_byte),
    .cmd           (cmd),
    .stat          (stat),
    .frame_byte    (frame_byte),
    .byte_position (byte_position),
    .check_ok      (check_ok),
    .last          (last)
  );

endmodule
